// ===== design/ctpe_pkg.sv =====
// ctpe_pkg: command and status words shared by the Cartesian tree
// paren encoder controller and datapath. No dependencies.
package ctpe_pkg;

   typedef struct packed {
      logic load;       // capture request word
      logic clear;      // empty the stack (new array)
      logic rd_top;     // read top of stack into read register
      logic pop;
      logic push;
      logic emit;       // load response register
      logic paren_val;
      logic run_end;
      logic code_end;
   } ctpe_cmd_type;

   typedef struct packed {
      logic empty;
      logic top_less;   // stacked top < captured value
      logic last;
      logic out_free;   // response register can take a word
   } ctpe_sts_type;

endpackage

// ===== design/ctpe_ctrl.sv =====
// ctpe_ctrl: sequencer for the paren encoder (root, compare/pop loop,
// push, flush, close). Depends on ctpe_pkg.
module ctpe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ctpe_pkg::ctpe_sts_type  sts,
   output ctpe_pkg::ctpe_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROOT  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_PUSH  = 3'd4;
   localparam logic [2:0] S_FLUSH = 3'd5;
   localparam logic [2:0] S_CLOSE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       started_ff, started_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!started_ff) begin
                  cmd.clear  = 1'b1;
                  started_in = 1'b1;
                  state_in   = S_ROOT;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_ROOT: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.paren_val = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            if (sts.empty) begin
               state_in = S_PUSH;
            end else begin
               cmd.rd_top = 1'b1;
               state_in   = S_CMP;
            end
         end
         S_CMP: begin
            if (!sts.top_less) begin
               state_in = S_PUSH;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.pop  = 1'b1;
               state_in = S_READ;
            end
         end
         S_PUSH: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.push      = 1'b1;
               cmd.paren_val = 1'b1;
               cmd.run_end   = !sts.last;
               state_in      = sts.last ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            if (sts.empty) begin
               state_in = S_CLOSE;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.pop  = 1'b1;
            end
         end
         S_CLOSE: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.run_end  = 1'b1;
               cmd.code_end = 1'b1;
               started_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
      end
   end

endmodule

// ===== design/ctpe_dpath.sv =====
// ctpe_dpath: value register, stack memory with top-of-stack read
// register, stack count and response register. Depends on ctpe_pkg.
module ctpe_dpath #(
   parameter int STACK_DEPTH = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic signed [31:0]      req_value,
   input  logic                    req_last,
   input  ctpe_pkg::ctpe_cmd_type  cmd,
   output ctpe_pkg::ctpe_sts_type  sts,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_paren_bit,
   output logic                    rsp_run_end,
   output logic                    rsp_code_end,
   output logic                    rsp_overflow
);

   localparam int AW       = $clog2(STACK_DEPTH);
   localparam int HELD_MAX = STACK_DEPTH - 1;
   localparam int EXT_W    = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

   logic signed [EXT_W-1:0]       value_ext;
   logic signed [VALUE_WIDTH-1:0] key_ff;
   logic                          last_ff;
   logic signed [VALUE_WIDTH-1:0] stack_ff [STACK_DEPTH];
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 rd_addr;
   logic                          full;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          paren_ff, run_end_ff, code_end_ff, ovf_ff;

   assign value_ext = EXT_W'(req_value);
   assign full      = (count_ff == AW'(HELD_MAX));
   assign rd_addr   = count_ff - AW'(1);

   assign sts.empty    = (count_ff == '0);
   assign sts.top_less = (rd_data_ff < key_ff);
   assign sts.last     = last_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff  <= value_ext[VALUE_WIDTH-1:0];
         last_ff <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         stack_ff[count_ff] <= key_ff;
      end
      if (cmd.rd_top) begin
         rd_data_ff <= stack_ff[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.pop) begin
         count_in = count_ff - AW'(1);
      end else if (cmd.push && !full) begin
         count_in = count_ff + AW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         paren_ff    <= cmd.paren_val;
         run_end_ff  <= cmd.run_end;
         code_end_ff <= cmd.code_end;
         ovf_ff      <= cmd.push && full;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_paren_bit = paren_ff;
   assign rsp_run_end   = run_end_ff;
   assign rsp_code_end  = code_end_ff;
   assign rsp_overflow  = ovf_ff;

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !sts.empty)
      else $error("pop on empty stack");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= AW'(HELD_MAX))
      else $error("stack count beyond capacity");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && !full) |=> (count_ff == $past(count_ff) + AW'(1)))
      else $error("push did not grow stack");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response word overwritten");

endmodule

// ===== design/cartesian_tree_paren_encoder_core.sv =====
// cartesian_tree_paren_encoder_core: top level of the Cartesian tree
// balanced-parentheses encoder. Depends on ctpe_pkg, ctpe_ctrl, ctpe_dpath.
//
//   channel | dir | ports
//   req     | in  | req_valid, req_ready, req_value, req_last
//   rsp     | out | rsp_valid, rsp_ready, rsp_paren_bit, rsp_run_end, rsp_code_end, rsp_overflow
//
// One word in flight: accept, then the root bit of a new array, then per pop a stack
// memory read and a compare, then a push (after an empty-stack read, or after the read
// and compare that end the pops).
// A last word adds the flush pops and then the close (empty check, then the close bit).
// Reset (synchronous) empties the stack and ends any array in progress.
// A stalled rsp side holds the sequencer at its next emitting step.
module cartesian_tree_paren_encoder_core #(
   parameter int STACK_DEPTH = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_paren_bit,
   output logic               rsp_run_end,
   output logic               rsp_code_end,
   output logic               rsp_overflow
);

   ctpe_pkg::ctpe_cmd_type cmd;
   ctpe_pkg::ctpe_sts_type sts;

   ctpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ctpe_dpath #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .req_last      (req_last),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_paren_bit (rsp_paren_bit),
      .rsp_run_end   (rsp_run_end),
      .rsp_code_end  (rsp_code_end),
      .rsp_overflow  (rsp_overflow)
   );

endmodule
